### hdl/bounded_decimal_text_writer_unit_defines.svh
// Assertion shorthands used by the checker file.
`ifndef BOUNDED_DECIMAL_TEXT_WRITER_UNIT_DEFINES_SVH
`define BOUNDED_DECIMAL_TEXT_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock and switched off during reset.
`define BDTW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and switched off during reset.
`define BDTW_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bdtw_pkg.sv
`timescale 1ns / 1ps

package bdtw_pkg;

   localparam int DEF_ADDR_BITS     = 16;
   localparam int BUF_SIZE_BITS     = 16;
   localparam int MAG_BITS          = 64;
   localparam int MAX_DIGITS        = 20;
   localparam int BCD_BITS          = 4 * MAX_DIGITS;
   localparam int DABBLE_BITS       = 4;
   localparam int CONV_STEPS        = MAG_BITS / DABBLE_BITS;
   localparam int CNT_BITS          = $clog2(CONV_STEPS);
   localparam int LEN_BITS          = 5;
   localparam int WORD_BITS         = 40;

   localparam logic [BUF_SIZE_BITS-1:0] BUFFER_SIZE_RESET = 16'hFFFF;
   localparam logic [7:0]  ASCII_ZERO = 8'h30;
   localparam logic [7:0]  ASCII_MINUS = 8'h2D;
   localparam logic [WORD_BITS-1:0] WORD_TRUE  = {"true", 8'h00};
   localparam logic [WORD_BITS-1:0] WORD_FALSE = "false";
   localparam logic [LEN_BITS-1:0]  LEN_TRUE   = 5'd4;
   localparam logic [LEN_BITS-1:0]  LEN_FALSE  = 5'd5;

   typedef enum logic [1:0] {
      OP_NUMBER  = 2'd0,
      OP_CHAR    = 2'd1,
      OP_WORD    = 2'd2,
      OP_SET_POS = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      NT_U8  = 3'd0,
      NT_U16 = 3'd1,
      NT_U32 = 3'd2,
      NT_U64 = 3'd3,
      NT_S16 = 3'd4,
      NT_S32 = 3'd5,
      NT_S64 = 3'd6
   } num_type;

   typedef enum logic [1:0] {
      RS_WRITTEN = 2'd0,
      RS_NONE    = 2'd1,
      RS_POS_SET = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_CHECK,
      ST_EMIT,
      ST_SINGLE
   } state_type;

   typedef struct packed {
      logic capture;
      logic conv_step;
      logic trim_step;
      logic check;
      logic emit_byte;
      logic single;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic conv_last;
      logic trim_done;
      logic fit;
      logic last_byte;
   } dp_stat_type;

   function automatic logic number_type_ok(input logic [2:0] t);
      return t <= NT_S64;
   endfunction

   // Four double-dabble steps: correct every BCD digit, then shift one bit in.
   function automatic logic [BCD_BITS+MAG_BITS-1:0] dabble_nibble(
      input logic [BCD_BITS+MAG_BITS-1:0] acc);
      logic [BCD_BITS+MAG_BITS-1:0] v;
      v = acc;
      for (int s = 0; s < DABBLE_BITS; s++) begin
         for (int d = 0; d < MAX_DIGITS; d++) begin
            if (v[MAG_BITS + 4*d +: 4] >= 4'd5) begin
               v[MAG_BITS + 4*d +: 4] = v[MAG_BITS + 4*d +: 4] + 4'd3;
            end
         end
         v = v << 1;
      end
      return v;
   endfunction

endpackage

### hdl/bdtw_ctrl.sv
`timescale 1ns / 1ps

module bdtw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_operation,
   input  logic [2:0]              req_number_type,
   input  bdtw_pkg::dp_stat_type   stat,
   output logic                    req_ready,
   output bdtw_pkg::dp_cmd_type    cmd
);
   import bdtw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (op_type'(req_operation))
                  OP_NUMBER: begin
                     state_in = number_type_ok(req_number_type) ? ST_CONVERT : ST_SINGLE;
                  end
                  OP_WORD:    state_in = ST_CHECK;
                  OP_CHAR:    state_in = ST_SINGLE;
                  OP_SET_POS: state_in = ST_SINGLE;
               endcase
            end
         end
         ST_CONVERT: begin
            if (stat.conv_last) state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (stat.trim_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.fit ? ST_EMIT : ST_SINGLE;
         end
         ST_EMIT: begin
            if (stat.out_free && stat.last_byte) state_in = ST_IDLE;
         end
         ST_SINGLE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CONVERT: cmd.conv_step = 1'b1;
         ST_TRIM:    cmd.trim_step = !stat.trim_done;
         ST_CHECK:   cmd.check     = 1'b1;
         ST_EMIT:    cmd.emit_byte = stat.out_free;
         ST_SINGLE:  cmd.single    = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### hdl/bdtw_datapath.sv
`timescale 1ns / 1ps

module bdtw_datapath #(
   parameter int ADDR_BITS = bdtw_pkg::DEF_ADDR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bdtw_pkg::dp_cmd_type   cmd,
   output bdtw_pkg::dp_stat_type  stat,
   input  logic [1:0]             req_operation,
   input  logic [63:0]            req_number,
   input  logic [2:0]             req_number_type,
   input  logic [7:0]             req_character,
   input  logic                   req_flag,
   input  logic [15:0]            req_new_position,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [15:0]            csr_buffer_size,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_write_address,
   output logic [7:0]             rsp_write_byte,
   output logic [1:0]             rsp_status,
   output logic                   rsp_ok_flag,
   output logic                   rsp_last
);
   import bdtw_pkg::*;

   // Wide enough for any position plus text length against the buffer size.
   localparam int CW = ((ADDR_BITS > BUF_SIZE_BITS) ? ADDR_BITS : BUF_SIZE_BITS) + 1;

   // Architectural state.
   logic [ADDR_BITS-1:0]     pos_ff;
   logic                     ok_ff;
   logic [BUF_SIZE_BITS-1:0] size_ff;

   // Item working registers.
   op_type                   op_ff;
   logic [7:0]               char_ff;
   logic                     word_flag_ff;
   logic [15:0]              npos_ff;
   logic                     neg_ff;
   logic [MAG_BITS-1:0]      bin_ff;
   logic [BCD_BITS-1:0]      bcd_ff;
   logic [CNT_BITS-1:0]      conv_cnt_ff;
   logic [LEN_BITS-1:0]      ndig_ff;
   logic [WORD_BITS-1:0]     word_ff;
   logic [LEN_BITS-1:0]      rem_ff;
   logic [15:0]              addr_ff;

   // Result register.
   logic                     rsp_valid_ff;
   logic [15:0]              rsp_addr_ff;
   logic [7:0]               rsp_byte_ff;
   rsp_status_type           rsp_status_ff;
   logic                     rsp_ok_ff;
   logic                     rsp_last_ff;

   logic [MAG_BITS-1:0]      cap_ze;
   logic [MAG_BITS-1:0]      cap_mask;
   logic                     cap_neg;
   logic [MAG_BITS-1:0]      cap_mag;
   logic [BCD_BITS+MAG_BITS-1:0] dabble_in;

   logic [CW-1:0]            pos_ext;
   logic [CW-1:0]            size_ext;
   logic [LEN_BITS-1:0]      text_len;
   logic [7:0]               emit_val;
   logic                     is_word;

   logic [ADDR_BITS-1:0]     npos_masked;
   logic [15:0]              single_addr;
   logic [7:0]               single_byte;
   rsp_status_type           single_status;
   logic                     single_ok;
   logic                     single_pos_we;
   logic [ADDR_BITS-1:0]     single_pos;

   // Magnitude and sign of the incoming integer.
   always_comb begin
      cap_ze   = '0;
      cap_mask = '1;
      cap_neg  = 1'b0;
      unique case (req_number_type)
         NT_U8:  cap_ze = {56'd0, req_number[7:0]};
         NT_U16: cap_ze = {48'd0, req_number[15:0]};
         NT_U32: cap_ze = {32'd0, req_number[31:0]};
         NT_U64: cap_ze = req_number;
         NT_S16: begin
            cap_ze   = {48'd0, req_number[15:0]};
            cap_mask = {48'd0, 16'hFFFF};
            cap_neg  = req_number[15];
         end
         NT_S32: begin
            cap_ze   = {32'd0, req_number[31:0]};
            cap_mask = {32'd0, 32'hFFFF_FFFF};
            cap_neg  = req_number[31];
         end
         NT_S64: begin
            cap_ze  = req_number;
            cap_neg = req_number[63];
         end
         default: begin
            cap_ze   = '0;
            cap_mask = '1;
            cap_neg  = 1'b0;
         end
      endcase
   end

   assign cap_mag   = cap_neg ? ((~cap_ze + 64'd1) & cap_mask) : cap_ze;
   assign dabble_in = dabble_nibble({bcd_ff, bin_ff});

   assign pos_ext  = CW'(pos_ff);
   assign size_ext = CW'(size_ff);
   assign is_word  = (op_ff == OP_WORD);
   assign text_len = is_word ? (word_flag_ff ? LEN_TRUE : LEN_FALSE)
                             : (ndig_ff + LEN_BITS'(neg_ff));
   assign emit_val = is_word ? word_ff[WORD_BITS-1 -: 8]
                   : (neg_ff ? ASCII_MINUS : (ASCII_ZERO | {4'd0, bcd_ff[BCD_BITS-1 -: 4]}));

   assign npos_masked = ADDR_BITS'(CW'(npos_ff));

   // One-result items: position load, raw character, and every failed write.
   always_comb begin
      single_addr   = pos_ext[15:0];
      single_byte   = '0;
      single_status = RS_NONE;
      single_ok     = 1'b0;
      single_pos_we = 1'b0;
      single_pos    = pos_ff + ADDR_BITS'(1);
      unique case (op_ff)
         OP_SET_POS: begin
            single_addr   = 16'(npos_masked);
            single_status = RS_POS_SET;
            single_ok     = ok_ff;
            single_pos_we = 1'b1;
            single_pos    = npos_masked;
         end
         OP_CHAR: begin
            single_ok = ok_ff && (pos_ext < size_ext);
            if (single_ok) begin
               single_byte   = char_ff;
               single_status = RS_WRITTEN;
               single_pos_we = 1'b1;
            end
         end
         OP_NUMBER, OP_WORD: begin
            single_ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ok_ff   <= 1'b1;
         size_ff <= BUFFER_SIZE_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            size_ff <= csr_buffer_size;
         end
         if (cmd.emit_byte) begin
            pos_ff <= pos_ff + ADDR_BITS'(1);
         end else if (cmd.single) begin
            ok_ff <= single_ok;
            if (single_pos_we) pos_ff <= single_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= op_type'(req_operation);
         char_ff      <= req_character;
         word_flag_ff <= req_flag;
         npos_ff      <= req_new_position;
         neg_ff       <= cap_neg;
         bin_ff       <= cap_mag;
         bcd_ff       <= '0;
         conv_cnt_ff  <= '0;
         ndig_ff      <= LEN_BITS'(MAX_DIGITS);
         word_ff      <= req_flag ? WORD_TRUE : WORD_FALSE;
      end else if (cmd.conv_step) begin
         bcd_ff      <= dabble_in[BCD_BITS+MAG_BITS-1 -: BCD_BITS];
         bin_ff      <= dabble_in[MAG_BITS-1:0];
         conv_cnt_ff <= conv_cnt_ff + CNT_BITS'(1);
      end else if (cmd.trim_step) begin
         bcd_ff  <= bcd_ff << 4;
         ndig_ff <= ndig_ff - LEN_BITS'(1);
      end else if (cmd.check) begin
         rem_ff  <= text_len;
         addr_ff <= pos_ext[15:0];
      end else if (cmd.emit_byte) begin
         rem_ff  <= rem_ff - LEN_BITS'(1);
         addr_ff <= addr_ff + 16'd1;
         if (is_word) begin
            word_ff <= word_ff << 8;
         end else if (neg_ff) begin
            // The sign goes out first; the digits follow from the top.
            neg_ff <= 1'b0;
         end else begin
            bcd_ff <= bcd_ff << 4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_byte || cmd.single) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_byte) begin
         rsp_addr_ff   <= addr_ff;
         rsp_byte_ff   <= emit_val;
         rsp_status_ff <= RS_WRITTEN;
         rsp_ok_ff     <= ok_ff;
         rsp_last_ff   <= (rem_ff == LEN_BITS'(1));
      end else if (cmd.single) begin
         rsp_addr_ff   <= single_addr;
         rsp_byte_ff   <= single_byte;
         rsp_status_ff <= single_status;
         rsp_ok_ff     <= single_ok;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.conv_last = (conv_cnt_ff == CNT_BITS'(CONV_STEPS - 1));
   assign stat.trim_done = (bcd_ff[BCD_BITS-1 -: 4] != 4'd0) || (ndig_ff == LEN_BITS'(1));
   assign stat.fit       = (pos_ext + CW'(text_len)) <= size_ext;
   assign stat.last_byte = (rem_ff == LEN_BITS'(1));

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_write_byte    = rsp_byte_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_ok_flag       = rsp_ok_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

### hdl/bounded_decimal_text_writer_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  operation, number, type, character, flag, position
// rsp       out        rsp_valid/rsp_ready  write_address, write_byte, status, ok_flag, last
// csr       in         csr_valid/csr_ready  buffer_size
//
// A number goes through binary-to-BCD conversion (four bits a cycle), then leading-zero removal
// (up to 19 shifts), the fit check, then one output byte per cycle while rsp is not stalled.
// A word goes through the check, then its bytes at that rate; a character or position load
// gives a single result. Every transaction passes through the idle state; the shared result
// register sets the byte rate, and a stalled rsp channel holds the sequencer in its emit or
// single-result state.
// Reset sets the position to 0, the success flag and the buffer size to 65535.

module bounded_decimal_text_writer_unit #(
   parameter int ADDR_BITS = bdtw_pkg::DEF_ADDR_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_operation,
   input  logic [63:0]  req_number,
   input  logic [2:0]   req_number_type,
   input  logic [7:0]   req_character,
   input  logic         req_flag,
   input  logic [15:0]  req_new_position,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [15:0]  rsp_write_address,
   output logic [7:0]   rsp_write_byte,
   output logic [1:0]   rsp_status,
   output logic         rsp_ok_flag,
   output logic         rsp_last,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_buffer_size
);
   import bdtw_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   bdtw_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_operation   (req_operation),
      .req_number_type (req_number_type),
      .stat            (stat),
      .req_ready       (req_ready),
      .cmd             (cmd)
   );

   bdtw_datapath #(
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_number        (req_number),
      .req_number_type   (req_number_type),
      .req_character     (req_character),
      .req_flag          (req_flag),
      .req_new_position  (req_new_position),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_buffer_size   (csr_buffer_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_status        (rsp_status),
      .rsp_ok_flag       (rsp_ok_flag),
      .rsp_last          (rsp_last)
   );

endmodule

### hdl/bdtw_checker.sv
`timescale 1ns / 1ps
`include "bounded_decimal_text_writer_unit_defines.svh"

module bdtw_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic [1:0]   req_operation,
   input logic [63:0]  req_number,
   input logic [2:0]   req_number_type,
   input logic [7:0]   req_character,
   input logic         req_flag,
   input logic [15:0]  req_new_position,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [15:0]  rsp_write_address,
   input logic [7:0]   rsp_write_byte,
   input logic [1:0]   rsp_status,
   input logic         rsp_ok_flag,
   input logic         rsp_last,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [15:0]  csr_buffer_size
);
   import bdtw_pkg::*;

   `BDTW_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_write_byte) && $stable(rsp_write_address), "result changed while stalled")

   // The writer works on one transaction at a time.
   `BDTW_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready, "transaction taken while busy")

   `BDTW_ASSERT_IMP(a_pos_last, rsp_valid && (rsp_status == RS_POS_SET), rsp_last, "position load not a lone result")

   // A refused write always clears the flag and carries no byte.
   `BDTW_ASSERT_IMP(a_fail_flag, rsp_valid && (rsp_status == RS_NONE), !rsp_ok_flag && (rsp_write_byte == 8'h00) && rsp_last, "refused write reported wrongly")

endmodule

bind bounded_decimal_text_writer_unit bdtw_checker u_checker (.*);
